[rtl/rrt_pkg.sv]
// Package for the reply receiver with timeouts: codes, config defaults and
// the result bundle passed from the decode core to the result sequencer.
// No dependencies.
package rrt_pkg;

   localparam int WaitW  = 24;
   localparam int LenW   = 16;
   localparam int CharW  = 8;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 24;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_BYTE  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RSN_TIMEOUT = 2'd0,
      RSN_TERM    = 2'd1,
      RSN_FULL    = 2'd2,
      RSN_RSVD    = 2'd3
   } reason_type;

   typedef enum logic {
      KIND_CHAR   = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FIRST_WAIT = 2'd0,
      CSR_MORE_WAIT  = 2'd1,
      CSR_BUF_SIZE   = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam logic [WaitW-1:0] FirstWaitRst = 24'd1000;
   localparam logic [LenW-1:0]  MoreWaitRst  = 16'd20;
   localparam logic [LenW-1:0]  BufSizeRst   = 16'd80;

   localparam logic [WaitW-1:0] WaitMax = {WaitW{1'b1}};
   localparam logic [LenW-1:0]  LenMax  = {LenW{1'b1}};

   // control bytes that close a read, then the characters used for escaping
   localparam logic [CharW-1:0] ChEtx = 8'h03;
   localparam logic [CharW-1:0] ChEot = 8'h04;
   localparam logic [CharW-1:0] ChLf  = 8'h0A;
   localparam logic [CharW-1:0] ChDle = 8'h10;
   localparam logic [CharW-1:0] ChEtb = 8'h17;
   localparam logic [CharW-1:0] ChSpace  = 8'h20;
   localparam logic [CharW-1:0] ChBslash = 8'h5C;
   localparam logic [CharW-1:0] ChZero   = 8'h30;

   typedef struct packed {
      logic [3:0][CharW-1:0] chars;
      logic [2:0]            n_chars;
      logic                  has_rpt;
      reason_type            reason;
      logic [LenW-1:0]       len;
      logic [WaitW-1:0]      lead_time;
      logic [WaitW-1:0]      longest_gap;
      logic [WaitW-1:0]      final_gap;
   } bundle_type;

endpackage

[rtl/reply_receiver_with_timeouts_unit.sv]
// Top level of the reply receiver with timeouts.
// Depends on rrt_pkg, rrt_core and rrt_emit.
//
//   channel  direction  transfer when          payload
//   req      in         req_valid & req_ready  opcode, rx_byte
//   rsp      out        rsp_valid & rsp_ready  kind, out_char, end_reason, reply_length,
//                                              lead_time, longest_gap, final_gap, last
//   csr      in         csr_we                 csr_index, csr_wdata
//
// An accepted item is decoded in its accept cycle; its results (0 to 5) show
// on rsp from the next cycle, one per transfer, the last flagged by rsp_last.
// An item with k results holds the result register until all k have transferred;
// the next item can be accepted in the cycle the last of them transfers.
// Reset (synchronous) clears the read state and loads the config defaults.
// rsp stalls back up into req_ready only while a bundle is still draining.
module reply_receiver_with_timeouts_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [rrt_pkg::CharW-1:0]     req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [rrt_pkg::CharW-1:0]     rsp_out_char,
   output logic [1:0]                    rsp_end_reason,
   output logic [rrt_pkg::LenW-1:0]      rsp_reply_length,
   output logic [rrt_pkg::WaitW-1:0]     rsp_lead_time,
   output logic [rrt_pkg::WaitW-1:0]     rsp_longest_gap,
   output logic [rrt_pkg::WaitW-1:0]     rsp_final_gap,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [rrt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [rrt_pkg::CsrDataW-1:0]  csr_wdata
);
   import rrt_pkg::*;

   logic       accept, push, free;
   bundle_type bundle;
   kind_type   kind;
   reason_type reason;

   assign req_ready = free;
   assign accept    = req_valid && free;

   rrt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (opcode_type'(req_opcode)),
      .rx_byte   (req_rx_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .bundle    (bundle)
   );

   rrt_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .bundle           (bundle),
      .free             (free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (kind),
      .rsp_out_char     (rsp_out_char),
      .rsp_end_reason   (reason),
      .rsp_reply_length (rsp_reply_length),
      .rsp_lead_time    (rsp_lead_time),
      .rsp_longest_gap  (rsp_longest_gap),
      .rsp_final_gap    (rsp_final_gap),
      .rsp_last         (rsp_last)
   );

   assign rsp_kind       = kind;
   assign rsp_end_reason = reason;

endmodule

[rtl/rrt_core.sv]
// Decode core: config registers, read state, and the per-item result bundle.
// Depends on rrt_pkg.
module rrt_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  rrt_pkg::opcode_type           opcode,
   input  logic [rrt_pkg::CharW-1:0]     rx_byte,
   input  logic                          csr_we,
   input  logic [rrt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [rrt_pkg::CsrDataW-1:0]  csr_wdata,
   output logic                          push,
   output rrt_pkg::bundle_type           bundle
);
   import rrt_pkg::*;

   logic [WaitW-1:0] first_wait_ff;
   logic [LenW-1:0]  more_wait_ff, buf_size_ff;

   logic             read_active_ff, read_active_in;
   logic             seen_first_ff, seen_first_in;
   logic [WaitW-1:0] wait_count_ff, wait_count_in;
   logic [LenW-1:0]  char_count_ff, char_count_in;
   logic [WaitW-1:0] lead_time_ff, lead_time_in;
   logic [WaitW-1:0] longest_gap_ff, longest_gap_in;

   logic [WaitW-1:0] limit;
   logic [LenW:0]    cc_sum;
   logic             is_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_wait_ff <= FirstWaitRst;
         more_wait_ff  <= MoreWaitRst;
         buf_size_ff   <= BufSizeRst;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_WAIT: first_wait_ff <= csr_wdata;
            CSR_MORE_WAIT:  more_wait_ff  <= csr_wdata[LenW-1:0];
            CSR_BUF_SIZE:   buf_size_ff   <= csr_wdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_active_ff <= 1'b0;
         seen_first_ff  <= 1'b0;
         wait_count_ff  <= '0;
         char_count_ff  <= '0;
         lead_time_ff   <= '0;
         longest_gap_ff <= '0;
      end else begin
         read_active_ff <= read_active_in;
         seen_first_ff  <= seen_first_in;
         wait_count_ff  <= wait_count_in;
         char_count_ff  <= char_count_in;
         lead_time_ff   <= lead_time_in;
         longest_gap_ff <= longest_gap_in;
      end
   end

   assign is_term = rx_byte inside {ChEtx, ChEot, ChLf, ChDle, ChEtb};

   always_comb begin
      read_active_in = read_active_ff;
      seen_first_in  = seen_first_ff;
      wait_count_in  = wait_count_ff;
      char_count_in  = char_count_ff;
      lead_time_in   = lead_time_ff;
      longest_gap_in = longest_gap_ff;
      bundle         = '0;
      limit          = seen_first_ff ? {{(WaitW-LenW){1'b0}}, more_wait_ff} : first_wait_ff;
      cc_sum         = '0;
      if (accept) begin
         case (opcode)
            OP_START: begin
               read_active_in = 1'b1;
               seen_first_in  = 1'b0;
               wait_count_in  = '0;
               char_count_in  = '0;
               if (first_wait_ff == '0) begin
                  bundle.has_rpt = 1'b1;
                  bundle.reason  = RSN_TIMEOUT;
               end
            end
            OP_TICK: begin
               if (read_active_ff) begin
                  if (wait_count_ff != WaitMax)
                     wait_count_in = wait_count_ff + 1'b1;
                  if (wait_count_in >= limit) begin
                     bundle.has_rpt   = 1'b1;
                     bundle.reason    = RSN_TIMEOUT;
                     bundle.final_gap = wait_count_in;
                  end
               end
            end
            OP_BYTE: begin
               if (read_active_ff) begin
                  if (!seen_first_ff) begin
                     seen_first_in = 1'b1;
                     lead_time_in  = wait_count_ff;
                  end else if (wait_count_ff > longest_gap_ff) begin
                     longest_gap_in = wait_count_ff;
                  end
                  wait_count_in = '0;
                  if (is_term) begin
                     bundle.has_rpt = 1'b1;
                     bundle.reason  = RSN_TERM;
                  end else begin
                     if (rx_byte < ChSpace) begin
                        // backslash, '0', then one or two octal digits
                        bundle.chars[0] = ChBslash;
                        bundle.chars[1] = ChZero;
                        if (rx_byte[4:3] != 2'b00) begin
                           bundle.chars[2] = ChZero + {6'b0, rx_byte[4:3]};
                           bundle.chars[3] = ChZero + {5'b0, rx_byte[2:0]};
                           bundle.n_chars  = 3'd4;
                        end else begin
                           bundle.chars[2] = ChZero + {5'b0, rx_byte[2:0]};
                           bundle.n_chars  = 3'd3;
                        end
                     end else begin
                        bundle.chars[0] = rx_byte;
                        bundle.n_chars  = 3'd1;
                     end
                     cc_sum = {1'b0, char_count_ff} + {{(LenW-2){1'b0}}, bundle.n_chars};
                     char_count_in = cc_sum[LenW] ? LenMax : cc_sum[LenW-1:0];
                     if ({1'b0, char_count_in} + 1'b1 >= {1'b0, buf_size_ff}) begin
                        bundle.has_rpt = 1'b1;
                        bundle.reason  = RSN_FULL;
                     end else if (more_wait_ff == '0) begin
                        bundle.has_rpt = 1'b1;
                        bundle.reason  = RSN_TIMEOUT;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (bundle.has_rpt) begin
         read_active_in     = 1'b0;
         bundle.len         = char_count_in;
         bundle.lead_time   = lead_time_in;
         bundle.longest_gap = longest_gap_in;
      end
   end

   assign push = accept && (bundle.n_chars != '0 || bundle.has_rpt);

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !read_active_ff && opcode != OP_START) |-> !push)
      else $error("result from an item outside a read");

   a_report_closes: assert property (@(posedge clock) disable iff (reset)
      (push && bundle.has_rpt) |=> !read_active_ff)
      else $error("read still open after its report");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_START && first_wait_ff != '0) |=>
      (read_active_ff && !seen_first_ff && char_count_ff == '0))
      else $error("start did not open a clean read");

endmodule

[rtl/rrt_emit.sv]
// Result sequencer: holds one bundle and sends its results one per transfer.
// Depends on rrt_pkg.
module rrt_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rrt_pkg::bundle_type         bundle,
   output logic                        free,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rrt_pkg::kind_type           rsp_kind,
   output logic [rrt_pkg::CharW-1:0]   rsp_out_char,
   output rrt_pkg::reason_type         rsp_end_reason,
   output logic [rrt_pkg::LenW-1:0]    rsp_reply_length,
   output logic [rrt_pkg::WaitW-1:0]   rsp_lead_time,
   output logic [rrt_pkg::WaitW-1:0]   rsp_longest_gap,
   output logic [rrt_pkg::WaitW-1:0]   rsp_final_gap,
   output logic                        rsp_last
);
   import rrt_pkg::*;

   bundle_type bundle_ff;
   logic       valid_ff;
   logic [2:0] idx_ff;
   logic [2:0] total;
   logic       at_last, take, is_rpt;

   assign total   = bundle_ff.n_chars + {2'b0, bundle_ff.has_rpt};
   assign at_last = (idx_ff == total - 3'd1);
   assign take    = valid_ff && rsp_ready;
   assign free    = !valid_ff || (take && at_last);
   assign is_rpt  = (idx_ff >= bundle_ff.n_chars);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (push) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take && at_last) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         bundle_ff <= bundle;
   end

   always_comb begin
      rsp_valid        = valid_ff;
      rsp_last         = at_last;
      rsp_kind         = is_rpt ? KIND_REPORT : KIND_CHAR;
      rsp_out_char     = is_rpt ? '0 : bundle_ff.chars[idx_ff[1:0]];
      rsp_end_reason   = is_rpt ? bundle_ff.reason : RSN_TIMEOUT;
      rsp_reply_length = is_rpt ? bundle_ff.len : '0;
      rsp_lead_time    = is_rpt ? bundle_ff.lead_time : '0;
      rsp_longest_gap  = is_rpt ? bundle_ff.longest_gap : '0;
      rsp_final_gap    = is_rpt ? bundle_ff.final_gap : '0;
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < total))
      else $error("sequencer index past bundle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      push |-> free)
      else $error("bundle loaded over pending results");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (take && at_last && !push) |=> !valid_ff)
      else $error("valid held after last transfer");

endmodule
